// File: hdl/kway_move_delta_gain_macros.svh
// assertion macros for the k-way move delta gain block
// used by the top level only, no other dependencies
`ifndef KWAY_MOVE_DELTA_GAIN_MACROS_SVH
`define KWAY_MOVE_DELTA_GAIN_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KMDG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmdg assertion failed");
// next-cycle implication
`define KMDG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmdg assertion failed");
`else
`define KMDG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KMDG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/kmdg_pkg.sv
// shared types, constants and helpers of the k-way move delta gain block
// no dependencies
`default_nettype none

package kmdg_pkg;

    localparam int PART_LIMIT  = 4;
    localparam int MAX_PINS    = 8;
    localparam int PART_SLOTS  = 4;
    localparam int PART_W      = 2;
    localparam int PIN_IDX_W   = $clog2(MAX_PINS);
    localparam int PIN_CNT_W   = 4;
    localparam int WEIGHT_W    = 16;
    localparam int GAIN_W      = WEIGHT_W + 2;
    localparam int DELTA_W     = 32;
    localparam int CFG_W       = 3;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 40;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = 1;
    localparam int Q_CNT_W     = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;

    // opcodes and result kinds
    localparam logic OP_START    = 1'b0;
    localparam logic OP_PIN      = 1'b1;
    localparam logic KIND_PIN    = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    // one unit of work passed from front to back
    typedef struct packed {
        logic                                     is_start;
        logic [PART_W-1:0]                        src;
        logic [PART_W-1:0]                        tgt;
        logic [WEIGHT_W-1:0]                      weight;
        logic [PIN_CNT_W-1:0]                     pin_count;
        logic [MAX_PINS-1:0][PART_W-1:0]          parts;
        logic [PART_SLOTS-1:0][PIN_CNT_W-1:0]     part_cnt;
    } t_job;

    // parts in use, clamped to 2..PART_LIMIT and to the part slots
    function automatic logic [CFG_W-1:0] parts_eff(input logic [CFG_W-1:0] cfg);
        logic [CFG_W-1:0] p;
        p = cfg;
        if (p > CFG_W'(PART_LIMIT)) p = CFG_W'(PART_LIMIT);
        if (p > CFG_W'(PART_SLOTS)) p = CFG_W'(PART_SLOTS);
        if (p < CFG_W'(2)) p = CFG_W'(2);
        return p;
    endfunction

endpackage

`default_nettype wire

// File: hdl/kway_move_delta_gain.sv
// k-way move gain update: a pin transaction is accepted whenever the job queue
// has room; with an idle back end the job of a net end passes the queue, the dequeue,
// the PASS1, PASS2 and EMIT states and the output register before its first result is valid.
// the back end then emits pin_count*P + P results for a net end, one result per cycle while
// the output is not stalled (P = parts in use). a start-move transaction produces no output.
// synchronous active-low reset clears control state, vertex deltas, and sets parts to 4.
`default_nettype none
`include "kway_move_delta_gain_macros.svh"

module kway_move_delta_gain (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [kmdg_pkg::CFG_W-1:0]          i_cfg_wr_data,  // parts_in_use
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [1:0] source_part, [3:2] target_part, [5:4] pin_part, [21:6] net_weight
    input  wire logic [kmdg_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  wire logic                                s_axis_tuser,   // [0] opcode
    input  wire logic                                s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [2:0] pin_index, [4:3] part_index, [36:5] delta
    output logic [kmdg_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    output logic                                     m_axis_tuser,   // [0] kind
    output logic                                     m_axis_tlast
);

    logic [kmdg_pkg::CFG_W-1:0]     r_cfg;
    logic [kmdg_pkg::CFG_W-1:0]     parts;
    logic                           q_push;
    logic                           q_pop;
    logic                           q_full;
    logic                           q_empty;
    kmdg_pkg::t_job                 job_in;
    kmdg_pkg::t_job                 job_out;
    logic                           out_vertex;
    logic [kmdg_pkg::PART_W-1:0]    out_part;
    logic [kmdg_pkg::PIN_IDX_W-1:0] out_pin;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= kmdg_pkg::CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_cfg <= i_cfg_wr_data;
        end
    end

    assign parts = kmdg_pkg::parts_eff(r_cfg);

    kmdg_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .s_axis_tlast   (s_axis_tlast),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_job        (job_in)
    );

    kmdg_queue u_queue (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (q_push),
        .i_job          (job_in),
        .i_pop          (q_pop),
        .o_job          (job_out),
        .o_full         (q_full),
        .o_empty        (q_empty)
    );

    kmdg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (job_out),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .i_parts        (parts),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast)
    );

    // result fields seen by the checks below
    assign out_vertex = (m_axis_tuser == kmdg_pkg::KIND_VERTEX);
    assign out_part   = m_axis_tdata[4:3];
    assign out_pin    = m_axis_tdata[2:0];

    // a run always ends on a vertex delta
    `KMDG_ASSERT_IMP(a_last_is_vertex, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, out_vertex)
    // results never name a part beyond those in use
    `KMDG_ASSERT_IMP(a_part_in_range, i_clk, i_rst_n, m_axis_tvalid, {1'b0, out_part} < parts)
    // vertex deltas carry pin index zero
    `KMDG_ASSERT_IMP(a_vertex_pin_zero, i_clk, i_rst_n, m_axis_tvalid && out_vertex, out_pin == '0)
    // a push into a full queue never happens
    `KMDG_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, q_full, !q_push)

endmodule

`default_nettype wire

// File: hdl/kmdg_front.sv
// front end: accepts input transactions, holds the pins of the current net
// and move parts, and queues a start or evaluate job; uses kmdg_pkg
`default_nettype none

module kmdg_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [kmdg_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  wire logic                               s_axis_tuser,
    input  wire logic                               s_axis_tlast,
    input  wire logic                               i_q_full,
    output logic                                    o_q_push,
    output kmdg_pkg::t_job                          o_q_job
);

    logic [kmdg_pkg::PART_W-1:0]                                r_parts [kmdg_pkg::MAX_PINS];
    logic [kmdg_pkg::PIN_CNT_W-1:0]                             r_cnt;
    logic [kmdg_pkg::PART_SLOTS-1:0][kmdg_pkg::PIN_CNT_W-1:0]   r_num;
    logic [kmdg_pkg::PART_W-1:0]                                r_src;
    logic [kmdg_pkg::PART_W-1:0]                                r_tgt;

    logic                                                       acc;
    logic                                                       store;
    logic [kmdg_pkg::PART_W-1:0]                                f_src;
    logic [kmdg_pkg::PART_W-1:0]                                f_tgt;
    logic [kmdg_pkg::PART_W-1:0]                                f_pin;
    logic [kmdg_pkg::WEIGHT_W-1:0]                              f_weight;
    logic [kmdg_pkg::PIN_CNT_W-1:0]                             upd_cnt;
    logic [kmdg_pkg::PART_SLOTS-1:0][kmdg_pkg::PIN_CNT_W-1:0]   upd_num;

    // field unpacking
    assign f_src    = s_axis_tdata[1:0];
    assign f_tgt    = s_axis_tdata[3:2];
    assign f_pin    = s_axis_tdata[5:4];
    assign f_weight = s_axis_tdata[21:6];

    assign s_axis_tready = !i_q_full;
    assign acc   = s_axis_tvalid && s_axis_tready;
    assign store = (s_axis_tuser == kmdg_pkg::OP_PIN)
                   && (r_cnt < kmdg_pkg::PIN_CNT_W'(kmdg_pkg::MAX_PINS));

    // pin count and per-part tallies including the pin in flight
    always_comb begin
        upd_cnt = r_cnt;
        upd_num = r_num;
        if (store) begin
            upd_cnt = r_cnt + kmdg_pkg::PIN_CNT_W'(1);
            upd_num[f_pin] = r_num[f_pin] + kmdg_pkg::PIN_CNT_W'(1);
        end
    end

    // job snapshot for the back end
    always_comb begin
        o_q_job.is_start  = (s_axis_tuser == kmdg_pkg::OP_START);
        o_q_job.src       = r_src;
        o_q_job.tgt       = r_tgt;
        o_q_job.weight    = f_weight;
        o_q_job.pin_count = upd_cnt;
        o_q_job.part_cnt  = upd_num;
        for (int i = 0; i < kmdg_pkg::MAX_PINS; i++) begin
            o_q_job.parts[i] = r_parts[i];
        end
        if (store) begin
            o_q_job.parts[r_cnt[kmdg_pkg::PIN_IDX_W-1:0]] = f_pin;
        end
    end

    assign o_q_push = acc && ((s_axis_tuser == kmdg_pkg::OP_START) || s_axis_tlast);

    // pin storage, written once per pin, no reset needed
    always_ff @(posedge i_clk) begin
        if (acc && store) begin
            r_parts[r_cnt[kmdg_pkg::PIN_IDX_W-1:0]] <= f_pin;
        end
    end

    // net and move state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_num <= '0;
            r_src <= '0;
            r_tgt <= '0;
        end else if (acc) begin
            if (s_axis_tuser == kmdg_pkg::OP_START) begin
                r_src <= f_src;
                r_tgt <= f_tgt;
                r_cnt <= '0;
                r_num <= '0;
            end else if (s_axis_tlast) begin
                r_cnt <= '0;
                r_num <= '0;
            end else begin
                r_cnt <= upd_cnt;
                r_num <= upd_num;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/kmdg_queue.sv
// two-entry job queue between front and back ends
// uses kmdg_pkg for the job type and depth
`default_nettype none

module kmdg_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire kmdg_pkg::t_job     i_job,
    input  wire logic               i_pop,
    output kmdg_pkg::t_job          o_job,
    output logic                    o_full,
    output logic                    o_empty
);

    kmdg_pkg::t_job                     r_mem [kmdg_pkg::Q_DEPTH];
    logic [kmdg_pkg::Q_PTR_W-1:0]       r_wp;
    logic [kmdg_pkg::Q_PTR_W-1:0]       r_rp;
    logic [kmdg_pkg::Q_CNT_W-1:0]       r_count;

    assign o_full  = (r_count == kmdg_pkg::Q_CNT_W'(kmdg_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rp];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= r_wp + kmdg_pkg::Q_PTR_W'(1);
            if (i_pop && !o_empty) r_rp <= r_rp + kmdg_pkg::Q_PTR_W'(1);
            case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_count <= r_count + kmdg_pkg::Q_CNT_W'(1);
                2'b01:   r_count <= r_count - kmdg_pkg::Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/kmdg_back.sv
// back end: applies the two gain passes to the vertex deltas and streams
// the pin-by-part and vertex deltas through an output register; uses kmdg_pkg
`default_nettype none

module kmdg_back (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire kmdg_pkg::t_job                      i_job,
    input  wire logic                                i_q_empty,
    output logic                                     o_q_pop,
    input  wire logic [kmdg_pkg::CFG_W-1:0]          i_parts,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [kmdg_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    output logic                                     m_axis_tuser,
    output logic                                     m_axis_tlast
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PASS1 = 2'd1;
    localparam logic [1:0] ST_PASS2 = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam int PAD_W = kmdg_pkg::OUT_DATA_W - kmdg_pkg::PIN_IDX_W
                           - kmdg_pkg::PART_W - kmdg_pkg::DELTA_W;

    logic [1:0]                                     r_state;
    kmdg_pkg::t_job                                 r_job;
    logic signed [kmdg_pkg::DELTA_W-1:0]            r_vd [kmdg_pkg::PART_SLOTS];
    logic [kmdg_pkg::PIN_IDX_W-1:0]                 r_pin;
    logic [kmdg_pkg::PART_W-1:0]                    r_part;
    logic                                           r_vphase;

    logic                                           r_valid;
    logic                                           r_kind;
    logic [kmdg_pkg::PIN_IDX_W-1:0]                 r_pin_idx;
    logic [kmdg_pkg::PART_W-1:0]                    r_part_idx;
    logic signed [kmdg_pkg::DELTA_W-1:0]            r_delta;
    logic                                           r_last;

    logic                                           out_free;
    logic                                           emit;
    logic                                           src_ok;
    logic                                           tgt_ok;
    logic [kmdg_pkg::PIN_CNT_W-1:0]                 cnt_s;
    logic [kmdg_pkg::PIN_CNT_W-1:0]                 cnt_t;
    logic                                           vd_dec;
    logic                                           vd_inc;
    logic                                           part_end;
    logic                                           pin_end;
    logic [kmdg_pkg::PART_W-1:0]                    cur_pin_part;
    logic signed [kmdg_pkg::GAIN_W-1:0]             gain;
    logic signed [kmdg_pkg::GAIN_W-1:0]             pin_delta;

    // saturating add of a signed 18-bit step to a 32-bit delta
    function automatic logic signed [kmdg_pkg::DELTA_W-1:0] sat_add(
        input logic signed [kmdg_pkg::DELTA_W-1:0] a,
        input logic signed [kmdg_pkg::GAIN_W-1:0]  b
    );
        logic signed [kmdg_pkg::DELTA_W:0] s;
        s = {a[kmdg_pkg::DELTA_W-1], a}
            + {{(kmdg_pkg::DELTA_W + 1 - kmdg_pkg::GAIN_W){b[kmdg_pkg::GAIN_W-1]}}, b};
        if (s[kmdg_pkg::DELTA_W] != s[kmdg_pkg::DELTA_W-1]) begin
            return {s[kmdg_pkg::DELTA_W], {(kmdg_pkg::DELTA_W-1){!s[kmdg_pkg::DELTA_W]}}};
        end
        return s[kmdg_pkg::DELTA_W-1:0];
    endfunction

    // pass conditions from the per-part pin tallies
    assign src_ok = {1'b0, r_job.src} < i_parts;
    assign tgt_ok = {1'b0, r_job.tgt} < i_parts;
    assign cnt_s  = r_job.part_cnt[r_job.src];
    assign cnt_t  = r_job.part_cnt[r_job.tgt];
    assign vd_dec = src_ok && (cnt_s == '0) && tgt_ok && (cnt_t != '0);
    assign vd_inc = tgt_ok && (cnt_t == '0) && src_ok && (cnt_s != '0);
    assign gain   = kmdg_pkg::GAIN_W'(r_job.weight);

    // pin delta for the current pin and part
    assign cur_pin_part = r_job.parts[r_pin];
    always_comb begin
        pin_delta = '0;
        if (src_ok && (cnt_s == '0) && (r_part == r_job.src)) pin_delta = pin_delta - gain;
        if (src_ok && (cnt_s == kmdg_pkg::PIN_CNT_W'(1)) && (cur_pin_part == r_job.src))
            pin_delta = pin_delta + gain;
        if (tgt_ok && (cnt_t == '0) && (r_part == r_job.tgt)) pin_delta = pin_delta + gain;
        if (tgt_ok && (cnt_t == kmdg_pkg::PIN_CNT_W'(1)) && (cur_pin_part == r_job.tgt))
            pin_delta = pin_delta - gain;
    end

    assign out_free = !r_valid || m_axis_tready;
    assign emit     = (r_state == ST_EMIT) && out_free;
    assign part_end = ({1'b0, r_part} == i_parts - kmdg_pkg::CFG_W'(1));
    assign pin_end  = ({1'b0, r_pin} == r_job.pin_count - kmdg_pkg::PIN_CNT_W'(1));
    assign o_q_pop  = (r_state == ST_IDLE) && !i_q_empty;

    // job latch
    always_ff @(posedge i_clk) begin
        if (o_q_pop && !i_job.is_start) begin
            r_job <= i_job;
        end
    end

    // sequencer and vertex delta lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pin    <= '0;
            r_part   <= '0;
            r_vphase <= 1'b0;
            for (int i = 0; i < kmdg_pkg::PART_SLOTS; i++) r_vd[i] <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (o_q_pop) begin
                        if (i_job.is_start) begin
                            for (int i = 0; i < kmdg_pkg::PART_SLOTS; i++) r_vd[i] <= '0;
                        end else begin
                            r_state <= ST_PASS1;
                        end
                    end
                end
                ST_PASS1: begin
                    for (int i = 0; i < kmdg_pkg::PART_SLOTS; i++) begin
                        if (vd_dec && ({1'b0, kmdg_pkg::PART_W'(i)} < i_parts))
                            r_vd[i] <= sat_add(r_vd[i], -gain);
                    end
                    r_state <= ST_PASS2;
                end
                ST_PASS2: begin
                    for (int i = 0; i < kmdg_pkg::PART_SLOTS; i++) begin
                        if (vd_inc && ({1'b0, kmdg_pkg::PART_W'(i)} < i_parts))
                            r_vd[i] <= sat_add(r_vd[i], gain);
                    end
                    r_pin    <= '0;
                    r_part   <= '0;
                    r_vphase <= (r_job.pin_count == '0);
                    r_state  <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (emit) begin
                        if (part_end) begin
                            r_part <= '0;
                            if (r_vphase) begin
                                r_state <= ST_IDLE;
                            end else if (pin_end) begin
                                r_vphase <= 1'b1;
                            end else begin
                                r_pin <= r_pin + kmdg_pkg::PIN_IDX_W'(1);
                            end
                        end else begin
                            r_part <= r_part + kmdg_pkg::PART_W'(1);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_free) begin
            r_valid <= emit;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_part_idx <= r_part;
            if (r_vphase) begin
                r_kind    <= kmdg_pkg::KIND_VERTEX;
                r_pin_idx <= '0;
                r_delta   <= r_vd[r_part];
                r_last    <= part_end;
            end else begin
                r_kind    <= kmdg_pkg::KIND_PIN;
                r_pin_idx <= r_pin;
                r_delta   <= kmdg_pkg::DELTA_W'(pin_delta);
                r_last    <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_delta, r_part_idx, r_pin_idx};

endmodule

`default_nettype wire
